### rtl/b64d_pkg.sv
`timescale 1ns / 1ps
// Package for the Base64 stream decoder: character codes, the work entry
// passed from the front end to the back end, and the alphabet lookup.
// No dependencies.
package b64d_pkg;

	localparam logic [7:0] CODE_PAD = 8'hFE;
	localparam logic [7:0] CODE_BAD = 8'hFF;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// One accepted character that causes results becomes one entry.
	// The entry carries up to three bytes, in the order they are emitted.
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      last_idx;
		logic            done;
		logic            fail;
	} b64d_entry_t;

	// Map an ASCII character to its 6-bit code, a pad mark or an invalid mark.
	function automatic logic [7:0] map_symbol(input logic [7:0] c);
		logic [7:0] r;
		r = CODE_BAD;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = c - 8'h41;
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r = c - 8'h61 + 8'd26;
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r = c - 8'h30 + 8'd52;
		end else if (c == 8'h2B) begin
			r = 8'd62;
		end else if (c == 8'h2F) begin
			r = 8'd63;
		end else if (c == 8'h3D) begin
			r = CODE_PAD;
		end
		return r;
	endfunction

endpackage

### rtl/b64d_front.sv
`timescale 1ns / 1ps
// Front end of the Base64 stream decoder: classifies each character, tracks
// the quartet and the discard state, and writes one entry per result group.
// Depends on b64d_pkg.
module b64d_front import b64d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  symbol,
	input  logic        message_end,
	output logic        wr_valid,
	output b64d_entry_t wr_entry
);

	logic [2:0][7:0] held_q, held_d;
	logic [1:0]      pos_q, pos_d;
	logic            disc_q, disc_d;

	// Decode state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			pos_q  <= '0;
			disc_q <= 1'b0;
		end else if (accept) begin
			held_q <= held_d;
			pos_q  <= pos_d;
			disc_q <= disc_d;
		end
	end

	// Classification of the current character and the entry it produces.
	always_comb begin
		logic [7:0] code;
		logic [7:0] c0, c1, c2;
		logic       fail;
		code     = map_symbol(symbol);
		c0       = held_q[0];
		c1       = held_q[1];
		c2       = held_q[2];
		fail     = 1'b0;
		held_d   = held_q;
		pos_d    = pos_q;
		disc_d   = disc_q;
		wr_valid = 1'b0;
		wr_entry = '0;
		if (disc_q) begin
			if (message_end) begin
				disc_d = 1'b0;
				pos_d  = '0;
			end
		end else if (code == CODE_BAD) begin
			fail = 1'b1;
		end else if (pos_q != 2'd3) begin
			if (message_end || (code == CODE_PAD && pos_q != 2'd2)) begin
				fail = 1'b1;
			end else begin
				held_d[pos_q] = code;
				pos_d         = pos_q + 2'd1;
			end
		end else if ((c2 == CODE_PAD && (code != CODE_PAD || !message_end)) ||
		             (c2 != CODE_PAD && code == CODE_PAD && !message_end)) begin
			fail = 1'b1;
		end else begin
			// The quartet completes: up to three bytes.
			pos_d             = '0;
			wr_valid          = 1'b1;
			wr_entry.done     = message_end;
			wr_entry.bytes[0] = {c0[5:0], c1[5:4]};
			wr_entry.bytes[1] = {c1[3:0], c2[5:2]};
			wr_entry.bytes[2] = {c2[1:0], code[5:0]};
			if (c2 == CODE_PAD) begin
				wr_entry.last_idx = 2'd0;
			end else if (code == CODE_PAD) begin
				wr_entry.last_idx = 2'd1;
			end else begin
				wr_entry.last_idx = 2'd2;
			end
		end
		// A malformed message gives one error beat.
		if (fail) begin
			pos_d         = '0;
			disc_d        = !message_end;
			wr_valid      = 1'b1;
			wr_entry      = '0;
			wr_entry.done = 1'b1;
			wr_entry.fail = 1'b1;
		end
		wr_valid = wr_valid && accept;
	end

endmodule

### rtl/b64d_queue.sv
`timescale 1ns / 1ps
// Short queue of work entries between the front end and the back end.
// Depends on b64d_pkg.
module b64d_queue import b64d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_valid,
	input  b64d_entry_t wr_entry,
	input  logic        rd_take,
	output logic        rd_valid,
	output b64d_entry_t rd_entry,
	output logic        full
);

	b64d_entry_t             slots_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0]       count_q;
	logic                    do_rd;

	assign do_rd    = rd_take && rd_valid;
	assign rd_valid = (count_q != '0);
	assign full     = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign rd_entry = slots_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr_valid) begin
			slots_q[wr_ptr_q] <= wr_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_valid) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (wr_valid && !do_rd) begin
				count_q <= count_q + (QUEUE_AW+1)'(1);
			end else if (!wr_valid && do_rd) begin
				count_q <= count_q - (QUEUE_AW+1)'(1);
			end
		end
	end

endmodule

### rtl/b64d_back.sv
`timescale 1ns / 1ps
// Back end of the Base64 stream decoder: walks the head entry's bytes and presents
// one registered result beat per cycle while pop is high and an entry waits.
// Depends on b64d_pkg.
module b64d_back import b64d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  b64d_entry_t head_entry,
	output logic        head_take,
	input  logic        pop,
	output logic        empty,
	output logic [7:0]  data_byte,
	output logic        run_last,
	output logic        message_done,
	output logic        failed
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic       load;
	logic       is_last;
	logic [7:0] sel_byte;

	assign empty   = !out_valid_q;
	assign load    = head_valid && (!out_valid_q || pop);
	assign is_last = (idx_q == head_entry.last_idx);
	assign head_take = load && is_last;

	// Pick the byte at the current index of the head entry.
	always_comb begin
		unique case (idx_q)
			2'd0:    sel_byte = head_entry.bytes[0];
			2'd1:    sel_byte = head_entry.bytes[1];
			2'd2:    sel_byte = head_entry.bytes[2];
			default: sel_byte = '0;
		endcase
	end

	// Output valid and byte index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			data_byte    <= sel_byte;
			run_last     <= is_last;
			message_done <= is_last && head_entry.done;
			failed       <= head_entry.fail;
		end
	end

endmodule

### rtl/base64_stream_decoder.sv
`timescale 1ns / 1ps
// Base64 stream decoder (standard alphabet, '=' padding). It takes one
// character beat per cycle whenever full is low, and a result beat leaves
// each cycle that pop is high and empty is low; a complete quartet yields
// up to three byte beats. When a character is accepted, the front end
// classifies it and writes any result group it causes into a four-entry
// queue, and the back end then loads the first result into its single
// output register, waiting while that register holds a beat not popped.
// Full rises only when the queue holds four pending result groups. A
// malformed message yields one beat with failed set, and further
// characters are dropped up to the message end.
// Depends on b64d_pkg, b64d_front, b64d_queue and b64d_back.
module base64_stream_decoder import b64d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] symbol,
	input  logic       message_end,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] data_byte,
	output logic       run_last,
	output logic       message_done,
	output logic       failed
);

	logic        accept;
	logic        wr_valid;
	b64d_entry_t wr_entry;
	logic        head_valid;
	logic        head_take;
	b64d_entry_t head_entry;

	assign accept = push && !full;

	// Character classification and quartet tracking.
	b64d_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.symbol      (symbol),
		.message_end (message_end),
		.wr_valid    (wr_valid),
		.wr_entry    (wr_entry)
	);

	// Decoupling queue.
	b64d_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (wr_valid),
		.wr_entry (wr_entry),
		.rd_take  (head_take),
		.rd_valid (head_valid),
		.rd_entry (head_entry),
		.full     (full)
	);

	// Result serialization.
	b64d_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_entry   (head_entry),
		.head_take    (head_take),
		.pop          (pop),
		.empty        (empty),
		.data_byte    (data_byte),
		.run_last     (run_last),
		.message_done (message_done),
		.failed       (failed)
	);

endmodule
